// ===== design/assert_macros.svh =====
// Assertion macros shared by the servo pulse schedule builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, disabled while i_rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled while i_rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spsb_pkg.sv =====
// Types and constants shared by the servo pulse schedule builder.
package spsb_pkg;

    localparam int IDX_W     = 3;
    localparam int POS_W     = 8;
    localparam int PULSE_W   = 16;
    localparam int MASK_W    = 8;
    localparam int PROD_W    = 32;
    localparam int REM_W     = 8;

    localparam logic [REM_W:0]    DIVISOR  = 9'd255;
    localparam logic [MASK_W-1:0] ALL_HIGH = 8'hFF;

    typedef struct packed {
        logic [IDX_W-1:0]   servo_index;
        logic [POS_W-1:0]   position;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
    } t_in_item;

    typedef struct packed {
        logic [PULSE_W-1:0] step_time;
        logic [MASK_W-1:0]  pin_mask;
        logic               is_last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic update;
        logic sort_phase;
        logic scan_step;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic index_ok;
        logic emit_needed;
        logic out_free;
    } t_sts;

endpackage

// ===== design/servo_pulse_schedule_builder.sv =====
// Top level of the servo pulse schedule builder.
// Each input transaction sets one servo's pulse length from its position and calibration,
// re-sorts the channels by length and then streams the whole schedule, from time 0 upwards,
// one output transaction per distinct length, the last flagged by is_last. One item is
// worked on at a time: the next is not accepted until the last entry has been loaded into
// the output register, and an output stall holds the sequence. The steps are the multiply,
// a remainder-by-255 step, the cell update, one odd/even transposition phase per channel
// over the sorted cell row, one cell read per channel while the schedule is scanned out,
// the final entry and the return to idle. An item whose servo index is not below CHANNELS
// is taken without leaving idle and gives no output.
`include "assert_macros.svh"

module servo_pulse_schedule_builder #(
    parameter int CHANNELS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spsb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spsb_pkg::t_out_item o_out_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    spsb_pkg::t_cmd  w_cmd;
    spsb_pkg::t_sts  w_sts;
    logic [CH_W-1:0] w_idx;
    logic            w_busy;
    logic            w_start;
    logic            w_out_load;
    logic            w_last_held;

    spsb_ctrl #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx),
        .o_busy     (w_busy)
    );

    spsb_datapath #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = w_busy;

    assign w_start     = i_in_valid && !o_in_stall && w_sts.index_ok;
    assign w_out_load  = (w_cmd.scan_step && w_sts.emit_needed) || w_cmd.emit_last;
    assign w_last_held = o_out_valid && o_out_data.is_last;

    `ASSERT_NEXT(a_valid_item_busies, w_start, o_in_stall, "accepted transaction did not start")
    `ASSERT_IMPLIES(a_no_overwrite, w_out_load, w_sts.out_free, "output register overwritten")
    `ASSERT_NEXT(a_last_goes_idle, w_cmd.emit_last, !o_in_stall && w_last_held, "no idle after last")

endmodule

// ===== design/spsb_datapath.sv =====
// Datapath: pulse length arithmetic, divide by 255, sorted cell row, schedule output.
module spsb_datapath #(
    parameter int CHANNELS = 8,
    parameter int CH_W     = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spsb_pkg::t_cmd      i_cmd,
    input  logic [CH_W-1:0]     i_idx,
    input  spsb_pkg::t_in_item  i_in_data,
    input  logic                i_out_stall,
    output spsb_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output spsb_pkg::t_out_item o_out_data
);

    typedef struct packed {
        logic [CH_W-1:0]              ch;
        logic [spsb_pkg::PULSE_W-1:0] len;
    } t_cell;

    t_cell r_cells [CHANNELS];
    t_cell n_cells [CHANNELS];
    t_cell w_left  [CHANNELS];
    t_cell w_right [CHANNELS];
    logic [CHANNELS-1:0] w_swap;
    logic [CHANNELS-1:0] w_swap_left;

    logic [CH_W-1:0]              r_ch;
    logic [spsb_pkg::POS_W-1:0]   r_pos;
    logic [spsb_pkg::PULSE_W-1:0] r_lo;
    logic [spsb_pkg::PROD_W-1:0]  r_diff;
    logic [spsb_pkg::PROD_W-1:0]  r_work;
    logic [spsb_pkg::REM_W-1:0]   r_rem;
    logic [spsb_pkg::PULSE_W-1:0] r_cur_time;
    logic [spsb_pkg::MASK_W-1:0]  r_cur_mask;
    logic                         r_out_valid;
    spsb_pkg::t_out_item          r_out_data;

    logic [9:0]                   w_byte_sum;
    logic [spsb_pkg::REM_W:0]     w_fold;
    logic [spsb_pkg::REM_W-1:0]   w_rem;
    logic [spsb_pkg::PULSE_W-1:0] w_exact;
    logic [spsb_pkg::PULSE_W-1:0] w_quot;
    logic [spsb_pkg::PULSE_W-1:0] w_new_len;
    t_cell                        w_sel;
    logic [spsb_pkg::MASK_W-1:0]  w_bit;
    logic                         w_out_load;

    // odd/even transposition neighbours
    for (genvar p = 0; p < CHANNELS; p++) begin : g_nb
        if (p < CHANNELS - 1) begin : g_r
            localparam logic PAR = 1'(p % 2);
            assign w_right[p] = r_cells[p+1];
            assign w_swap[p]  = (i_idx[0] == PAR) && (r_cells[p].len > r_cells[p+1].len);
        end else begin : g_rn
            assign w_right[p] = r_cells[p];
            assign w_swap[p]  = 1'b0;
        end
        if (p > 0) begin : g_l
            assign w_left[p]      = r_cells[p-1];
            assign w_swap_left[p] = w_swap[p-1];
        end else begin : g_ln
            assign w_left[p]      = r_cells[p];
            assign w_swap_left[p] = 1'b0;
        end
    end

    // 256 is 1 modulo 255, so the byte sum keeps the remainder
    always_comb begin
        w_byte_sum = {2'b00, r_work[7:0]} + {2'b00, r_work[15:8]} +
                     {2'b00, r_work[23:16]} + {2'b00, r_work[31:24]};
        w_fold     = {1'b0, w_byte_sum[7:0]} + {7'b0, w_byte_sum[9:8]};
        w_rem      = (w_fold >= spsb_pkg::DIVISOR) ?
                     spsb_pkg::REM_W'(w_fold - spsb_pkg::DIVISOR) :
                     w_fold[spsb_pkg::REM_W-1:0];
    end

    // low quotient bits: exact multiple times the inverse of 255 modulo 2^16, i.e. -257
    always_comb begin
        w_exact = r_work[spsb_pkg::PULSE_W-1:0] - spsb_pkg::PULSE_W'(r_rem);
        w_quot  = -(w_exact + (w_exact << 8));
    end

    assign w_new_len = (r_pos == '0) ? '0 : r_lo + w_quot;

    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            n_cells[k] = r_cells[k];
            if (i_cmd.update) begin
                if (r_cells[k].ch == r_ch) begin
                    n_cells[k].len = w_new_len;
                end
            end else if (i_cmd.sort_phase) begin
                if (w_swap[k]) begin
                    n_cells[k] = w_right[k];
                end else if (w_swap_left[k]) begin
                    n_cells[k] = w_left[k];
                end
            end
        end
    end

    always_comb begin
        w_sel = r_cells[i_idx];
        w_bit = '0;
        if (32'(w_sel.ch) < spsb_pkg::MASK_W) begin
            w_bit = spsb_pkg::MASK_W'(1) << w_sel.ch;
        end
    end

    assign o_sts.index_ok    = (32'(i_in_data.servo_index) < CHANNELS);
    assign o_sts.emit_needed = (w_sel.len != r_cur_time);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign w_out_load = (i_cmd.scan_step && o_sts.emit_needed) || i_cmd.emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_cells[k].ch  <= CH_W'(k);
                r_cells[k].len <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_cells <= n_cells;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= CH_W'(i_in_data.servo_index);
            r_pos  <= i_in_data.position;
            r_lo   <= i_in_data.min_pulse;
            r_diff <= spsb_pkg::PROD_W'(i_in_data.max_pulse) -
                      spsb_pkg::PROD_W'(i_in_data.min_pulse);
        end
        if (i_cmd.mul) begin
            r_work <= spsb_pkg::PROD_W'(spsb_pkg::PROD_W'(r_pos) * r_diff);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem;
        end
        if (i_cmd.update) begin
            r_cur_time <= '0;
            r_cur_mask <= spsb_pkg::ALL_HIGH;
        end
        if (i_cmd.scan_step) begin
            if (o_sts.emit_needed) begin
                r_cur_time <= w_sel.len;
            end
            r_cur_mask <= r_cur_mask & ~w_bit;
        end
        if (i_cmd.scan_step && o_sts.emit_needed) begin
            r_out_data.step_time <= r_cur_time;
            r_out_data.pin_mask  <= r_cur_mask;
            r_out_data.is_last   <= 1'b0;
        end else if (i_cmd.emit_last) begin
            r_out_data.step_time <= r_cur_time;
            r_out_data.pin_mask  <= r_cur_mask;
            r_out_data.is_last   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/spsb_ctrl.sv =====
// Controller: sequences multiply, divide, cell update, sort phases and schedule scan.
module spsb_ctrl #(
    parameter int CHANNELS = 8,
    parameter int CH_W     = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  spsb_pkg::t_sts  i_sts,
    output spsb_pkg::t_cmd  o_cmd,
    output logic [CH_W-1:0] o_idx,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_UPD,
        S_SORT,
        S_SCAN,
        S_LAST
    } t_state;

    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

    t_state          r_state;
    logic [CH_W-1:0] r_cnt;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.update     = (r_state == S_UPD);
        o_cmd.sort_phase = (r_state == S_SORT);
        o_cmd.scan_step  = (r_state == S_SCAN) && !(i_sts.emit_needed && !i_sts.out_free);
        o_cmd.emit_last  = (r_state == S_LAST) && i_sts.out_free;
    end

    assign o_idx  = r_cnt;
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_sts.index_ok) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_cnt   <= '0;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (r_cnt == LAST_IDX) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (o_cmd.scan_step) begin
                        if (r_cnt == LAST_IDX) begin
                            r_state <= S_LAST;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_LAST: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
